### rtl/core/voc_pkg.sv
package voc_pkg;

    localparam int X_CELLS = 64;
    localparam int Y_CELLS = 64;
    localparam int Z_CELLS = 16;
    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W = 16;
    localparam int Q_W = 16;
    localparam int OFF_W = 26;
    localparam int DIV_CNT_W = 5;

    localparam logic [2:0] REG_SIZE_X = 3'd0;
    localparam logic [2:0] REG_SIZE_Y = 3'd1;
    localparam logic [2:0] REG_SIZE_Z = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd3;
    localparam logic [2:0] REG_LIMIT = 3'd4;
    localparam logic [2:0] REG_OCC_TH = 3'd5;
    localparam logic [2:0] REG_FREE_TH = 3'd6;

    localparam logic CMD_HIT = 1'b0;
    localparam logic CMD_MISS = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic signed [23:0] point_z;
    } t_request;

    typedef struct packed {
        logic               in_map;
        logic [15:0]        voxel_index;
        logic signed [7:0]  hit_count;
        logic               occupied;
    } t_result;

    typedef struct packed {
        logic [15:0]       size_x;
        logic [15:0]       size_y;
        logic [15:0]       size_z;
        logic signed [23:0] origin_z;
        logic [6:0]        limit;
        logic signed [7:0] occ_th;
        logic signed [7:0] free_th;
    } t_cfg;

    typedef struct packed {
        logic              in_map;
        logic              cmd;
        logic [ADDR_W-1:0] addr;
    } t_job;

endpackage

### rtl/core/voc_ram.sv
module voc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/voc_front.sv
module voc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  voc_pkg::t_cfg      i_cfg,
    input  logic               i_start,
    input  voc_pkg::t_request  i_req,
    output logic               o_busy,
    output logic               o_job_valid,
    output voc_pkg::t_job      o_job,
    input  logic               i_job_ready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic [voc_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic r_cmd, n_cmd;
    logic r_ok, n_ok;
    logic signed [voc_pkg::OFF_W-1:0] r_off [3];
    logic signed [voc_pkg::OFF_W-1:0] n_off [3];
    logic [voc_pkg::OFF_W-2:0] r_quo, n_quo;
    logic [16:0] r_rem, n_rem;
    logic [voc_pkg::Q_W-1:0] r_idx [3];
    logic [voc_pkg::Q_W-1:0] n_idx [3];

    logic [15:0] w_size;
    logic [voc_pkg::OFF_W-1:0] w_off;
    logic [16:0] w_trial;
    logic [16:0] w_diff;
    logic [voc_pkg::Q_W-1:0] w_cells;
    logic [31:0] w_lin;

    always_comb begin
        case (r_axis)
            2'd0:    begin w_size = i_cfg.size_x; w_cells = 16'(voc_pkg::X_CELLS); end
            2'd1:    begin w_size = i_cfg.size_y; w_cells = 16'(voc_pkg::Y_CELLS); end
            default: begin w_size = i_cfg.size_z; w_cells = 16'(voc_pkg::Z_CELLS); end
        endcase
    end

    assign w_off = r_off[r_axis];
    assign w_trial = {r_rem[15:0], w_off[voc_pkg::OFF_W - 2 - 32'(r_cnt)]};
    assign w_diff = w_trial - {1'b0, w_size};
    assign w_lin = 32'(r_idx[2]) * 32'(voc_pkg::X_CELLS * voc_pkg::Y_CELLS)
                 + 32'(r_idx[1]) * 32'(voc_pkg::X_CELLS) + 32'(r_idx[0]);

    always_comb begin
        n_state = r_state;
        n_axis = r_axis;
        n_cnt = r_cnt;
        n_cmd = r_cmd;
        n_ok = r_ok;
        n_off = r_off;
        n_quo = r_quo;
        n_rem = r_rem;
        n_idx = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_cmd = i_req.cmd;
                    n_off[0] = 26'(i_req.point_x)
                             + 26'(voc_pkg::X_CELLS / 2) * 26'(i_cfg.size_x);
                    n_off[1] = 26'(i_req.point_y)
                             + 26'(voc_pkg::Y_CELLS / 2) * 26'(i_cfg.size_y);
                    n_off[2] = 26'(i_req.point_z) - 26'(i_cfg.origin_z);
                    n_ok = 1'b1;
                    n_axis = 2'd0;
                    n_cnt = '0;
                    n_quo = '0;
                    n_rem = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_trial >= {1'b0, w_size}) begin
                    n_rem = w_diff;
                    n_quo = {r_quo[voc_pkg::OFF_W-3:0], 1'b1};
                end else begin
                    n_rem = w_trial;
                    n_quo = {r_quo[voc_pkg::OFF_W-3:0], 1'b0};
                end
                if (r_cnt == 5'(voc_pkg::OFF_W - 2)) begin
                    if (w_off[voc_pkg::OFF_W-1] || w_off == '0 || w_size == '0
                        || n_quo >= (voc_pkg::OFF_W-1)'(w_cells)) begin
                        n_ok = 1'b0;
                    end
                    n_idx[r_axis] = n_quo[voc_pkg::Q_W-1:0];
                    n_cnt = '0;
                    n_quo = '0;
                    n_rem = '0;
                    if (r_axis == 2'd2) begin
                        n_state = ST_OUT;
                    end else begin
                        n_axis = r_axis + 2'd1;
                    end
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ST_OUT: begin
                if (i_job_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_axis <= n_axis;
        r_cnt <= n_cnt;
        r_cmd <= n_cmd;
        r_ok <= n_ok;
        r_off <= n_off;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_idx <= n_idx;
    end

    assign o_busy = r_state != ST_IDLE;
    assign o_job_valid = r_state == ST_OUT;
    assign o_job.in_map = r_ok;
    assign o_job.cmd = r_cmd;
    assign o_job.addr = w_lin[voc_pkg::ADDR_W-1:0];

endmodule

### rtl/core/voc_back.sv
module voc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  voc_pkg::t_cfg      i_cfg,
    input  logic               i_job_valid,
    input  voc_pkg::t_job      i_job,
    output logic               o_job_ready,
    output logic               o_done,
    output voc_pkg::t_result   o_res
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0] r_state, n_state;
    logic [voc_pkg::ADDR_W:0] r_clr, n_clr;
    voc_pkg::t_job r_job;
    logic r_done;
    voc_pkg::t_result r_res, n_res;

    logic w_we;
    logic [voc_pkg::ADDR_W-1:0] w_waddr;
    logic [8:0] w_wdata;
    logic [8:0] w_rdata;
    logic signed [8:0] w_c;
    logic signed [8:0] w_lim;
    logic w_occ;

    voc_ram #(.WIDTH(9), .DEPTH(voc_pkg::STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (i_job.addr),
        .o_rdata (w_rdata)
    );

    assign w_lim = 9'(i_cfg.limit);

    always_comb begin
        w_occ = w_rdata[8];
        if (r_job.cmd == voc_pkg::CMD_HIT) begin
            w_c = 9'(signed'(w_rdata[7:0])) + 9'sd1;
            if (w_c > w_lim) w_c = w_lim;
            if (w_c > 9'(i_cfg.occ_th)) w_occ = 1'b1;
        end else begin
            w_c = 9'(signed'(w_rdata[7:0])) - 9'sd1;
            if (w_c < -w_lim) w_c = -w_lim;
            if (w_c < 9'(i_cfg.free_th)) w_occ = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        w_we = 1'b0;
        w_waddr = r_job.addr;
        w_wdata = {w_occ, w_c[7:0]};
        n_res = '0;
        case (r_state)
            ST_CLEAR: begin
                w_we = 1'b1;
                w_waddr = r_clr[voc_pkg::ADDR_W-1:0];
                w_wdata = '0;
                n_clr = r_clr + 17'd1;
                if (r_clr[voc_pkg::ADDR_W-1:0] == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_job_valid) n_state = ST_READ;
            end
            ST_READ: begin
                w_we = r_job.in_map;
                if (r_job.in_map) begin
                    n_res.in_map = 1'b1;
                    n_res.voxel_index = r_job.addr;
                    n_res.hit_count = w_c[7:0];
                    n_res.occupied = w_occ;
                end
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr <= '0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_done <= r_state == ST_READ;
        end
        if (r_state == ST_IDLE) r_job <= i_job;
        r_res <= n_res;
    end

    assign o_job_ready = r_state == ST_IDLE;
    assign o_done = r_done;
    assign o_res = r_res;

endmodule

### rtl/core/voxel_occupancy_counter_update_core.sv
// Channel | Ports                        | Handshake
// request | start, i_req                  | accepted when start and not busy
// result  | o_done, o_res                | one cycle strobe, cannot be held off
// config  | psel, penable, pwrite, paddr | APB write, pready always high
// A request passes through the front divider axis by axis, one quotient bit per
// cycle, then waits in hand-off until the back stage takes it; busy stays high
// until then. The back stage reads the voxel store, writes the updated entry
// and registers the result; a new request can be accepted before it strobes.
// After reset all 65536 store entries are cleared, one entry per cycle, while
// one request can wait in the front. Results cannot be stalled by the receiver.
module voxel_occupancy_counter_update_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  voc_pkg::t_request i_req,
    output logic              o_done,
    output voc_pkg::t_result  o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    voc_pkg::t_cfg r_cfg;
    logic w_wr;
    logic w_job_valid, w_job_ready;
    voc_pkg::t_job w_job;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_x <= 16'd100;
            r_cfg.size_y <= 16'd100;
            r_cfg.size_z <= 16'd100;
            r_cfg.origin_z <= '0;
            r_cfg.limit <= 7'd10;
            r_cfg.occ_th <= 8'sd3;
            r_cfg.free_th <= -8'sd3;
        end else if (w_wr) begin
            case (paddr[4:2])
                voc_pkg::REG_SIZE_X:   r_cfg.size_x <= pwdata[15:0];
                voc_pkg::REG_SIZE_Y:   r_cfg.size_y <= pwdata[15:0];
                voc_pkg::REG_SIZE_Z:   r_cfg.size_z <= pwdata[15:0];
                voc_pkg::REG_ORIGIN_Z: r_cfg.origin_z <= pwdata[23:0];
                voc_pkg::REG_LIMIT:    r_cfg.limit <= pwdata[6:0];
                voc_pkg::REG_OCC_TH:   r_cfg.occ_th <= pwdata[7:0];
                voc_pkg::REG_FREE_TH:  r_cfg.free_th <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            voc_pkg::REG_SIZE_X:   prdata = 32'(r_cfg.size_x);
            voc_pkg::REG_SIZE_Y:   prdata = 32'(r_cfg.size_y);
            voc_pkg::REG_SIZE_Z:   prdata = 32'(r_cfg.size_z);
            voc_pkg::REG_ORIGIN_Z: prdata = 32'(r_cfg.origin_z);
            voc_pkg::REG_LIMIT:    prdata = 32'(r_cfg.limit);
            voc_pkg::REG_OCC_TH:   prdata = 32'(r_cfg.occ_th);
            voc_pkg::REG_FREE_TH:  prdata = 32'(r_cfg.free_th);
            default:               prdata = '0;
        endcase
    end

    voc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (start),
        .i_req       (i_req),
        .o_busy      (busy),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_ready (w_job_ready)
    );

    voc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_ready (w_job_ready),
        .o_done      (o_done),
        .o_res       (o_res)
    );

endmodule

### rtl/core/voc_checker.sv
module voc_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input voc_pkg::t_result o_res,
    input logic             pready
);

    a_ready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_res.in_map |-> o_res.voxel_index == '0 && o_res.hit_count == '0
        && !o_res.occupied)
        else $error("outside result not zero");
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy missing after request");
    a_count_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.occupied |-> o_res.in_map)
        else $error("occupied outside map");

endmodule

bind voxel_occupancy_counter_update_core voc_checker u_voc_checker (.*);
